/* sv/rsk_pkg.sv */
// Package for the record sorter: record layout, key codes, key selection.
package rsk_pkg;

   localparam int unsigned MAX_RECORDS_DEF = 32;

   localparam int unsigned TAG_W  = 16;
   localparam int unsigned YEAR_W = 12;
   localparam int unsigned BAT_W  = 10;
   localparam int unsigned OBP_W  = 10;
   localparam int unsigned SLG_W  = 12;
   localparam int unsigned KEY_W  = 12;
   localparam int unsigned RANK_W = 6;
   localparam int unsigned SEL_W  = 2;

   localparam logic [SEL_W-1:0] KEY_BAT  = 2'd0;
   localparam logic [SEL_W-1:0] KEY_OBP  = 2'd1;
   localparam logic [SEL_W-1:0] KEY_SLG  = 2'd2;
   localparam logic [SEL_W-1:0] KEY_YEAR = 2'd3;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [YEAR_W-1:0] year;
      logic [BAT_W-1:0]  bat;
      logic [OBP_W-1:0]  obp;
      logic [SLG_W-1:0]  slg;
   } rec_type;

   function automatic logic [KEY_W-1:0] key_of(input rec_type r, input logic [SEL_W-1:0] sel);
      logic [KEY_W-1:0] k;
      k = '0;
      unique case (sel)
         KEY_BAT:  k = KEY_W'(r.bat);
         KEY_OBP:  k = KEY_W'(r.obp);
         KEY_SLG:  k = KEY_W'(r.slg);
         KEY_YEAR: k = KEY_W'(r.year);
         default:  k = '0;
      endcase
      return k;
   endfunction

endpackage

/* sv/rsk_store.sv */
// Record store: one write port, one read port, registered read data.
module rsk_store #(
   parameter int unsigned DEPTH = rsk_pkg::MAX_RECORDS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  rsk_pkg::rec_type         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output rsk_pkg::rec_type         rd_data
);

   rsk_pkg::rec_type mem [DEPTH];
   rsk_pkg::rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/record_sort_by_selected_key.sv */
// Record sorter top level: load, in-memory stable insertion sort, ranked readout.
//
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_stall  | one record, req_last_in ends the set
//  rsp_    | out       | rsp_valid/rsp_stall  | one ranked record per transaction
//  csr_    | in        | csr_wr_en            | sort key select, 2 bits
//
// Loading takes one record per cycle. After the last record, the sort runs in the
// record memory (one write port, one read port): for record i, ST_FETCH reads it,
// ST_CUR captures it, ST_CMP moves each record with a smaller key one slot up and
// ST_PLACE writes record i into the freed slot. Readout: ST_OISSUE reads the first
// result, then one result per cycle while rsp_stall is low. req_stall is high from
// the last record until the final result is taken. Reset clears control state only.
module record_sort_by_selected_key #(
   parameter int unsigned MAX_RECORDS = rsk_pkg::MAX_RECORDS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [rsk_pkg::TAG_W-1:0]   req_record_tag,
   input  logic [rsk_pkg::YEAR_W-1:0]  req_season_year,
   input  logic [rsk_pkg::BAT_W-1:0]   req_batting_avg,
   input  logic [rsk_pkg::OBP_W-1:0]   req_on_base,
   input  logic [rsk_pkg::SLG_W-1:0]   req_slugging,
   input  logic                        req_last_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rsk_pkg::TAG_W-1:0]   rsp_out_tag,
   output logic [rsk_pkg::YEAR_W-1:0]  rsp_out_year,
   output logic [rsk_pkg::BAT_W-1:0]   rsp_out_batting,
   output logic [rsk_pkg::OBP_W-1:0]   rsp_out_on_base,
   output logic [rsk_pkg::SLG_W-1:0]   rsp_out_slugging,
   output logic [rsk_pkg::RANK_W-1:0]  rsp_rank,
   output logic                        rsp_dropped,
   output logic                        rsp_last_out,
   input  logic                        csr_wr_en,
   input  logic [rsk_pkg::SEL_W-1:0]   csr_wr_data
);

   localparam int unsigned AW = $clog2(MAX_RECORDS);
   localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

   typedef enum logic [6:0] {
      ST_LOAD   = 7'b0000001,
      ST_FETCH  = 7'b0000010,
      ST_CUR    = 7'b0000100,
      ST_CMP    = 7'b0001000,
      ST_PLACE  = 7'b0010000,
      ST_OISSUE = 7'b0100000,
      ST_OSHOW  = 7'b1000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [CW-1:0]              count_ff, count_in;
   logic                       overflow_ff, overflow_in;
   logic [rsk_pkg::SEL_W-1:0]  key_ff;
   logic [rsk_pkg::SEL_W-1:0]  sel_ff, sel_in;
   logic [AW-1:0]              i_ff, i_in;
   logic [AW-1:0]              j_ff, j_in;
   logic [AW-1:0]              k_ff, k_in;
   rsk_pkg::rec_type           cur_ff, cur_in;

   logic                       req_acc;
   logic                       rsp_acc;
   logic                       has_room;
   logic [CW-1:0]              load_count;
   logic                       shift_down;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   rsk_pkg::rec_type           wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   rsk_pkg::rec_type           rd_data;
   rsk_pkg::rec_type           req_rec;

   rsk_store #(.DEPTH(MAX_RECORDS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = (state_ff == ST_OSHOW);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid && !rsp_stall;

   assign req_rec.tag  = req_record_tag;
   assign req_rec.year = req_season_year;
   assign req_rec.bat  = req_batting_avg;
   assign req_rec.obp  = req_on_base;
   assign req_rec.slg  = req_slugging;

   assign has_room   = (count_ff < CW'(MAX_RECORDS));
   assign load_count = has_room ? (count_ff + CW'(1)) : count_ff;
   assign shift_down = (rsk_pkg::key_of(rd_data, sel_ff) < rsk_pkg::key_of(cur_ff, sel_ff));

   assign rsp_out_tag      = rd_data.tag;
   assign rsp_out_year     = rd_data.year;
   assign rsp_out_batting  = rd_data.bat;
   assign rsp_out_on_base  = rd_data.obp;
   assign rsp_out_slugging = rd_data.slg;
   assign rsp_rank         = rsk_pkg::RANK_W'(k_ff);
   assign rsp_dropped      = overflow_ff;
   assign rsp_last_out     = ((CW'(k_ff) + CW'(1)) == count_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      sel_in      = sel_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      cur_in      = cur_ff;
      wr_en       = 1'b0;
      wr_addr     = j_ff;
      wr_data     = rd_data;
      rd_en       = 1'b0;
      rd_addr     = i_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (has_room) begin
                  wr_en   = 1'b1;
                  wr_addr = count_ff[AW-1:0];
                  wr_data = req_rec;
               end else begin
                  overflow_in = 1'b1;
               end
               count_in = load_count;
               if (req_last_in) begin
                  sel_in   = key_ff;
                  i_in     = AW'(1);
                  k_in     = '0;
                  state_in = (load_count == CW'(1)) ? ST_OISSUE : ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            rd_en    = 1'b1;
            rd_addr  = i_ff;
            state_in = ST_CUR;
         end
         ST_CUR: begin
            cur_in   = rd_data;
            j_in     = i_ff;
            rd_en    = 1'b1;
            rd_addr  = i_ff - AW'(1);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (shift_down) begin
               wr_en   = 1'b1;
               wr_addr = j_ff;
               wr_data = rd_data;
               j_in    = j_ff - AW'(1);
               if (j_ff != AW'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = j_ff - AW'(2);
               end else begin
                  state_in = ST_PLACE;
               end
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = cur_ff;
            if ((CW'(i_ff) + CW'(1)) == count_ff) begin
               k_in     = '0;
               state_in = ST_OISSUE;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = ST_FETCH;
            end
         end
         ST_OISSUE: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff;
            state_in = ST_OSHOW;
         end
         ST_OSHOW: begin
            if (rsp_acc) begin
               if (rsp_last_out) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
                  state_in    = ST_LOAD;
               end else begin
                  k_in    = k_ff + AW'(1);
                  rd_en   = 1'b1;
                  rd_addr = k_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         key_ff      <= rsk_pkg::KEY_BAT;
         sel_ff      <= rsk_pkg::KEY_BAT;
         i_ff        <= '0;
         j_ff        <= '0;
         k_ff        <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         sel_ff      <= sel_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         k_ff        <= k_in;
         if (csr_wr_en) begin
            key_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RECORDS))
      else $error("stored count beyond capacity");

   a_busy_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (count_ff != '0))
      else $error("sort or readout with empty set");

   a_cmp_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> ((j_ff != '0) && (j_ff <= i_ff)))
      else $error("insertion index out of range");

   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CW'(k_ff) < count_ff))
      else $error("rank beyond stored count");

   a_set_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_last_out) |=> ((count_ff == '0) && !overflow_ff && (state_ff == ST_LOAD)))
      else $error("set state not cleared after final transaction");

endmodule

/* verif/record_sort_by_selected_key_test.sv */
// Testbench for the record sorter: random and directed record sets, each ranked result checked.
module record_sort_by_selected_key_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CAPACITY      = rsk_pkg::MAX_RECORDS_DEF;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned ITEM_BUDGET   = 370;
   localparam int unsigned IDLE_PCT      = 32;
   localparam int unsigned HOLD_CYCLES   = 1500;

   typedef enum {SPREAD_FULL, SPREAD_RANGE, SPREAD_TIES} spread_type;

   typedef struct {
      rsk_pkg::rec_type           rec;
      logic [rsk_pkg::RANK_W-1:0] rank;
      logic                       dropped;
      logic                       last_out;
   } ranked_type;

   logic                         clock;
   logic                         reset            = 1'b1;
   logic                         req_valid        = 1'b0;
   logic                         req_stall;
   logic [rsk_pkg::TAG_W-1:0]    req_record_tag   = '0;
   logic [rsk_pkg::YEAR_W-1:0]   req_season_year  = '0;
   logic [rsk_pkg::BAT_W-1:0]    req_batting_avg  = '0;
   logic [rsk_pkg::OBP_W-1:0]    req_on_base      = '0;
   logic [rsk_pkg::SLG_W-1:0]    req_slugging     = '0;
   logic                         req_last_in      = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall        = 1'b0;
   logic [rsk_pkg::TAG_W-1:0]    rsp_out_tag;
   logic [rsk_pkg::YEAR_W-1:0]   rsp_out_year;
   logic [rsk_pkg::BAT_W-1:0]    rsp_out_batting;
   logic [rsk_pkg::OBP_W-1:0]    rsp_out_on_base;
   logic [rsk_pkg::SLG_W-1:0]    rsp_out_slugging;
   logic [rsk_pkg::RANK_W-1:0]   rsp_rank;
   logic                         rsp_dropped;
   logic                         rsp_last_out;
   logic                         csr_wr_en        = 1'b0;
   logic [rsk_pkg::SEL_W-1:0]    csr_wr_data      = '0;

   logic [rsk_pkg::SEL_W-1:0]    active_key       = rsk_pkg::KEY_BAT;
   rsk_pkg::rec_type             set_records[$];
   logic                         set_overflow     = 1'b0;
   ranked_type                   ranked_expect[$];
   int                           mismatch_count   = 0;
   int                           items_sent       = 0;
   int unsigned                  sender_idle_pct  = IDLE_PCT;
   int unsigned                  receiver_idle_pct = IDLE_PCT;
   int                           hold_request     = 0;
   int                           hold_left        = 0;

   record_sort_by_selected_key #(
      .MAX_RECORDS(CAPACITY)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_record_tag   (req_record_tag),
      .req_season_year  (req_season_year),
      .req_batting_avg  (req_batting_avg),
      .req_on_base      (req_on_base),
      .req_slugging     (req_slugging),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_year     (rsp_out_year),
      .rsp_out_batting  (rsp_out_batting),
      .rsp_out_on_base  (rsp_out_on_base),
      .rsp_out_slugging (rsp_out_slugging),
      .rsp_rank         (rsp_rank),
      .rsp_dropped      (rsp_dropped),
      .rsp_last_out     (rsp_last_out),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [rsk_pkg::KEY_W-1:0] key_value(
         input rsk_pkg::rec_type r, input logic [rsk_pkg::SEL_W-1:0] sel);
      logic [rsk_pkg::KEY_W-1:0] k;
      case (sel)
         rsk_pkg::KEY_BAT: k = rsk_pkg::KEY_W'(r.bat);
         rsk_pkg::KEY_OBP: k = rsk_pkg::KEY_W'(r.obp);
         rsk_pkg::KEY_SLG: k = rsk_pkg::KEY_W'(r.slg);
         default:          k = rsk_pkg::KEY_W'(r.year);
      endcase
      return k;
   endfunction

   function automatic rsk_pkg::rec_type make_record(
         input logic [rsk_pkg::TAG_W-1:0]  tag,
         input logic [rsk_pkg::YEAR_W-1:0] year,
         input logic [rsk_pkg::BAT_W-1:0]  bat,
         input logic [rsk_pkg::OBP_W-1:0]  obp,
         input logic [rsk_pkg::SLG_W-1:0]  slg);
      rsk_pkg::rec_type r;
      r.tag  = tag;
      r.year = year;
      r.bat  = bat;
      r.obp  = obp;
      r.slg  = slg;
      return r;
   endfunction

   function automatic rsk_pkg::rec_type rand_record(input spread_type spread);
      rsk_pkg::rec_type r;
      r.tag = rsk_pkg::TAG_W'($urandom);
      case (spread)
         SPREAD_FULL: begin
            r.year = rsk_pkg::YEAR_W'($urandom);
            r.bat  = rsk_pkg::BAT_W'($urandom);
            r.obp  = rsk_pkg::OBP_W'($urandom);
            r.slg  = rsk_pkg::SLG_W'($urandom);
         end
         SPREAD_RANGE: begin
            r.year = rsk_pkg::YEAR_W'($urandom_range(2030, 1871));
            r.bat  = rsk_pkg::BAT_W'($urandom_range(1000));
            r.obp  = rsk_pkg::OBP_W'($urandom_range(1000));
            r.slg  = rsk_pkg::SLG_W'($urandom_range(4000));
         end
         default: begin
            // narrow ranges so that every key has frequent ties
            r.year = rsk_pkg::YEAR_W'($urandom_range(2003, 2000));
            r.bat  = rsk_pkg::BAT_W'($urandom_range(252, 250));
            r.obp  = rsk_pkg::OBP_W'($urandom_range(331, 330));
            r.slg  = rsk_pkg::SLG_W'($urandom_range(402, 400));
         end
      endcase
      return r;
   endfunction

   // Stable descending ranking of the finished set; queues one result per stored record.
   task automatic rank_set();
      rsk_pkg::rec_type ordered[$];
      rsk_pkg::rec_type cur;
      ranked_type       res;
      int               j;
      ordered = set_records;
      for (int i = 1; i < ordered.size(); i++) begin
         cur = ordered[i];
         j = i;
         while (j > 0 && key_value(ordered[j-1], active_key) < key_value(cur, active_key)) begin
            ordered[j] = ordered[j-1];
            j--;
         end
         ordered[j] = cur;
      end
      foreach (ordered[k]) begin
         res.rec      = ordered[k];
         res.rank     = rsk_pkg::RANK_W'(k);
         res.dropped  = set_overflow;
         res.last_out = (k == ordered.size() - 1);
         ranked_expect.push_back(res);
      end
      set_records.delete();
      set_overflow = 1'b0;
   endtask

   task automatic absorb_record(input rsk_pkg::rec_type r, input logic last);
      if (set_records.size() < CAPACITY) begin
         set_records.push_back(r);
      end else begin
         set_overflow = 1'b1;
      end
      if (last) begin
         rank_set();
      end
   endtask

   task automatic send_record(input rsk_pkg::rec_type r, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_record_tag  <= r.tag;
      req_season_year <= r.year;
      req_batting_avg <= r.bat;
      req_on_base     <= r.obp;
      req_slugging    <= r.slg;
      req_last_in     <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      absorb_record(r, last);
   endtask

   task automatic send_set(input int count, input spread_type spread);
      for (int i = 0; i < count; i++) begin
         send_record(rand_record(spread), i == count - 1);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ranked_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sort_key(input logic [rsk_pkg::SEL_W-1:0] sel);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= sel;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_key = sel;
   endtask

   // Reset key: extremes, beyond-range values, ties; then one short set per other key.
   task automatic test_directed();
      logic [rsk_pkg::SEL_W-1:0] other_keys[3] = '{rsk_pkg::KEY_OBP, rsk_pkg::KEY_SLG,
                                                   rsk_pkg::KEY_YEAR};
      send_record(make_record('1, '1, '1, '1, '1), 1'b1);
      send_record(make_record('0, '0, '0, '0, '0), 1'b1);
      send_record(make_record(16'h0011, 12'd1990, 10'd0,    10'd400, 12'd500), 1'b0);
      send_record(make_record(16'h0012, 12'd1991, 10'd1023, 10'd0,   12'd4095), 1'b0);
      send_record(make_record(16'h0013, 12'd1992, 10'd1000, 10'd1000, 12'd4000), 1'b0);
      send_record(make_record(16'h0014, 12'd1993, 10'd500,  10'd1023, 12'd0), 1'b1);
      for (int i = 0; i < 5; i++) begin
         send_record(make_record(rsk_pkg::TAG_W'(16'h0100 + i),
                                 rsk_pkg::YEAR_W'(2000 - i), 10'd300,
                                 rsk_pkg::OBP_W'(i * 100),
                                 rsk_pkg::SLG_W'(4095 - i)), i == 4);
      end
      foreach (other_keys[i]) begin
         wait_drained();
         write_sort_key(other_keys[i]);
         send_record(make_record(16'h0201, '1, '1, '1, '1), 1'b0);
         send_record(make_record(16'h0202, '0, '0, '0, '0), 1'b0);
         send_record(make_record(16'h0203, '1, '1, '1, '1), 1'b1);
      end
      wait_drained();
   endtask

   // Store full: dropped records, including a dropped last record.
   task automatic test_overflow();
      write_sort_key(rsk_pkg::KEY_SLG);
      send_set(CAPACITY + 1, SPREAD_FULL);
      wait_drained();
      send_set(CAPACITY + 4, SPREAD_TIES);
      wait_drained();
      send_set(CAPACITY, SPREAD_RANGE);
      wait_drained();
   endtask

   // Receiver holds off while the next set is already offered.
   task automatic test_pressure();
      write_sort_key(rsk_pkg::KEY_BAT);
      hold_request = HOLD_CYCLES;
      send_set(CAPACITY, SPREAD_RANGE);
      send_set(6, SPREAD_FULL);
      wait_drained();
   endtask

   task automatic test_no_idle();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_sort_key(rsk_pkg::KEY_OBP);
      send_set(8, SPREAD_TIES);
      send_set(1, SPREAD_FULL);
      send_set(CAPACITY, SPREAD_FULL);
      send_set(5, SPREAD_RANGE);
      wait_drained();
      sender_idle_pct   = IDLE_PCT;
      receiver_idle_pct = IDLE_PCT;
   endtask

   task automatic test_random();
      int phase;
      int pick;
      int set_size;
      phase = 0;
      while (items_sent < ITEM_BUDGET) begin
         if (phase == 0) begin
            write_sort_key(rsk_pkg::KEY_YEAR);
         end else if (phase == 1) begin
            write_sort_key(rsk_pkg::KEY_BAT);
         end else begin
            write_sort_key(rsk_pkg::SEL_W'($urandom_range(3)));
         end
         repeat ($urandom_range(4, 2)) begin
            pick = $urandom_range(15);
            if (pick == 0) begin
               set_size = CAPACITY - 1 + $urandom_range(4);
            end else begin
               set_size = 1 + $urandom_range(7);
            end
            send_set(set_size, spread_type'($urandom_range(2)));
         end
         wait_drained();
         phase++;
      end
   endtask

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // One result transaction per accepted cycle, compared with the oldest expectation.
   always @(posedge clock) begin
      ranked_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ranked_expect.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result: tag %h rank %0d last %b",
                        rsp_out_tag, rsp_rank, rsp_last_out);
            end
         end else begin
            want = ranked_expect.pop_front();
            if (rsp_out_tag !== want.rec.tag || rsp_out_year !== want.rec.year ||
                rsp_out_batting !== want.rec.bat || rsp_out_on_base !== want.rec.obp ||
                rsp_out_slugging !== want.rec.slg || rsp_rank !== want.rank ||
                rsp_dropped !== want.dropped || rsp_last_out !== want.last_out) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display({"expected: tag %h year %0d bat %0d obp %0d slg %0d",
                            " rank %0d drop %b last %b"},
                           want.rec.tag, want.rec.year, want.rec.bat, want.rec.obp,
                           want.rec.slg, want.rank, want.dropped, want.last_out);
                  $display({"actual:   tag %h year %0d bat %0d obp %0d slg %0d",
                            " rank %0d drop %b last %b"},
                           rsp_out_tag, rsp_out_year, rsp_out_batting, rsp_out_on_base,
                           rsp_out_slugging, rsp_rank, rsp_dropped, rsp_last_out);
               end
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_pressure();
      test_no_idle();
      test_random();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/rsk_pkg.sv
sv/rsk_store.sv
sv/record_sort_by_selected_key.sv
verif/record_sort_by_selected_key_test.sv
